// ===== sv/t3ls_pkg.sv =====
// Package for the 3x3 transposed solver: widths, term tables and shared types.
`timescale 1ns / 1ps
`default_nettype none
package t3ls_pkg;

    // Field and datapath widths.
    localparam int W_DATA        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_OPS         = 12;
    localparam int N_LANES       = 4;
    localparam int N_TERMS       = 6;
    localparam int W_TERM        = 97;
    localparam int W_SUM         = 98;
    localparam int W_MAG         = 96;
    localparam int Q_BITS        = 33;

    // Saturation limits.
    localparam logic [W_DATA-1:0] SOL_MAX = 32'h7FFF_FFFF;
    localparam logic [W_DATA-1:0] SOL_MIN = 32'h8000_0000;

    // One triple product: three operand indexes and a negate flag.
    typedef struct packed {
        logic [3:0] i0;
        logic [3:0] i1;
        logic [3:0] i2;
        logic       neg;
    } t_term;

    // Lane 0 is the determinant, lanes 1 to 3 are the numerators.
    localparam t_term TERMS [N_LANES][N_TERMS] = '{
        '{'{4'd0, 4'd4, 4'd8, 1'b0}, '{4'd0, 4'd7, 4'd5, 1'b1}, '{4'd3, 4'd1, 4'd8, 1'b1},
          '{4'd6, 4'd1, 4'd5, 1'b0}, '{4'd3, 4'd2, 4'd7, 1'b0}, '{4'd6, 4'd2, 4'd4, 1'b1}},
        '{'{4'd9, 4'd4, 4'd8, 1'b0}, '{4'd9, 4'd5, 4'd7, 1'b1}, '{4'd10, 4'd3, 4'd8, 1'b1},
          '{4'd10, 4'd5, 4'd6, 1'b0}, '{4'd11, 4'd3, 4'd7, 1'b0}, '{4'd11, 4'd4, 4'd6, 1'b1}},
        '{'{4'd0, 4'd10, 4'd8, 1'b0}, '{4'd0, 4'd11, 4'd7, 1'b1}, '{4'd1, 4'd9, 4'd8, 1'b1},
          '{4'd1, 4'd11, 4'd6, 1'b0}, '{4'd2, 4'd9, 4'd7, 1'b0}, '{4'd2, 4'd10, 4'd6, 1'b1}},
        '{'{4'd0, 4'd4, 4'd11, 1'b0}, '{4'd0, 4'd5, 4'd10, 1'b1}, '{4'd1, 4'd3, 4'd11, 1'b1},
          '{4'd1, 4'd5, 4'd9, 1'b0}, '{4'd2, 4'd3, 4'd10, 1'b0}, '{4'd2, 4'd4, 4'd9, 1'b1}}
    };

    // Control that travels with the divider stages.
    typedef struct packed {
        logic       singular;
        logic [2:0] neg;
    } t_div_ctl;

    // One result item.
    typedef struct packed {
        logic [W_DATA-1:0] sol_0;
        logic [W_DATA-1:0] sol_1;
        logic [W_DATA-1:0] sol_2;
        logic              singular;
        logic              saturated;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/t3ls_ifs.sv =====
// Stream interfaces for the input and result channels of the 3x3 solver.
`timescale 1ns / 1ps
`default_nettype none
interface t3ls_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_0;
    logic signed [31:0] a_1;
    logic signed [31:0] a_2;
    logic signed [31:0] a_3;
    logic signed [31:0] a_4;
    logic signed [31:0] a_5;
    logic signed [31:0] a_6;
    logic signed [31:0] a_7;
    logic signed [31:0] a_8;
    logic signed [31:0] rhs_0;
    logic signed [31:0] rhs_1;
    logic signed [31:0] rhs_2;
    modport source (output valid, a_0, a_1, a_2, a_3, a_4, a_5, a_6, a_7, a_8,
                    rhs_0, rhs_1, rhs_2, input ready);
    modport sink (input valid, a_0, a_1, a_2, a_3, a_4, a_5, a_6, a_7, a_8,
                  rhs_0, rhs_1, rhs_2, output ready);
endinterface

interface t3ls_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sol_0;
    logic signed [31:0] sol_1;
    logic signed [31:0] sol_2;
    logic               singular;
    logic               saturated;
    modport source (output valid, sol_0, sol_1, sol_2, singular, saturated, input ready);
    modport sink (input valid, sol_0, sol_1, sol_2, singular, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/transposed_3x3_linear_solve.sv =====
// Top level of the pipelined 3x3 transposed linear solver by Cramer's rule.
//
//  Channel  Direction  Payload                                Transfer
//  i_in     sink       a_0..a_8, rhs_0..rhs_2 (Q16.16)        valid && ready
//  o_out    source     sol_0..sol_2, singular, saturated      valid && ready
//
// One item is accepted per cycle while i_in.ready is high.
// The item passes five product-sum stages, one sign stage, 35 divider stages (an overflow
// check, 33 quotient bits and saturation) and the output register, the first loaded at the
// transfer edge itself.
// Reset clears only the valid bits of the stages, the output register and the skid entry.
// A stalled output parks one result in a skid entry; i_in.ready is low only while it is full,
// and the whole pipeline then holds, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module transposed_3x3_linear_solve #(
    parameter int FRAC_BITS = t3ls_pkg::FRAC_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    t3ls_in_if.sink      i_in,
    t3ls_out_if.source   o_out
);
    import t3ls_pkg::*;

    localparam int NW  = W_MAG + FRAC_BITS;
    localparam int NST = 5 + 1 + Q_BITS + 2;

    logic               w_en;
    logic [NST-1:0]     r_vld;
    logic signed [W_DATA-1:0] w_op  [N_OPS];
    logic signed [W_SUM-1:0]  w_sum [N_LANES];
    logic signed [W_SUM-1:0]  w_neg [N_LANES];
    logic [W_MAG-1:0]   w_mag [N_LANES];
    logic [W_MAG-1:0]   r_dmag;
    logic [NW-1:0]      r_nsh [3];
    t_div_ctl           r_ctl;
    t_res               w_res;
    t_res               r_out;
    t_res               r_skid;
    logic               r_out_vld;
    logic               r_skid_vld;
    logic               w_take;

    // The pipeline advances whenever the skid entry is free.
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;

    assign w_op[0]  = i_in.a_0;
    assign w_op[1]  = i_in.a_1;
    assign w_op[2]  = i_in.a_2;
    assign w_op[3]  = i_in.a_3;
    assign w_op[4]  = i_in.a_4;
    assign w_op[5]  = i_in.a_5;
    assign w_op[6]  = i_in.a_6;
    assign w_op[7]  = i_in.a_7;
    assign w_op[8]  = i_in.a_8;
    assign w_op[9]  = i_in.rhs_0;
    assign w_op[10] = i_in.rhs_1;
    assign w_op[11] = i_in.rhs_2;

    // Valid bits travel with the data through every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    t3ls_sum u_sum (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_op  (w_op),
        .o_sum (w_sum)
    );

    // Sign stage: magnitudes, quotient signs, zero check and the fraction shift.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            w_neg[l] = W_SUM'(0) - w_sum[l];
            w_mag[l] = w_sum[l][W_SUM-1] ? w_neg[l][W_MAG-1:0] : w_sum[l][W_MAG-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dmag         <= w_mag[0];
            r_ctl.singular <= (w_sum[0] == '0);
            for (int j = 0; j < 3; j++) begin
                r_nsh[j]     <= {w_mag[j+1], {FRAC_BITS{1'b0}}};
                r_ctl.neg[j] <= w_sum[j+1][W_SUM-1] ^ w_sum[0][W_SUM-1];
            end
        end
    end

    t3ls_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_dmag),
        .i_n   (r_nsh),
        .i_ctl (r_ctl),
        .o_res (w_res)
    );

    // Output register with one skid entry behind it.
    assign w_take = r_out_vld && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= r_vld[NST-1];
        end else if (r_vld[NST-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.sol_0     = r_out.sol_0;
    assign o_out.sol_1     = r_out.sol_1;
    assign o_out.sol_2     = r_out.sol_2;
    assign o_out.singular  = r_out.singular;
    assign o_out.saturated = r_out.saturated;

`ifndef ASSERT_OFF
    // The skid entry only fills behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds a result while the output register is empty");

    // A singular result carries a zero solution and no saturation.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |->
        (o_out.sol_0 == '0 && o_out.sol_1 == '0 && o_out.sol_2 == '0 && !o_out.saturated))
        else $error("singular result with nonzero solution or saturation");

    // A saturated result holds at least one clipped element.
    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
        (o_out.sol_0 == SOL_MAX || o_out.sol_0 == SOL_MIN ||
         o_out.sol_1 == SOL_MAX || o_out.sol_1 == SOL_MIN ||
         o_out.sol_2 == SOL_MAX || o_out.sol_2 == SOL_MIN))
        else $error("saturated flag without a clipped element");
`endif

endmodule
`default_nettype wire

// ===== sv/t3ls_sum.sv =====
// Five-stage pipeline forming the determinant and three numerators as sums of triple products.
`timescale 1ns / 1ps
`default_nettype none
module t3ls_sum (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic signed [t3ls_pkg::W_DATA-1:0] i_op [t3ls_pkg::N_OPS],
    output logic signed [t3ls_pkg::W_SUM-1:0]     o_sum [t3ls_pkg::N_LANES]
);
    import t3ls_pkg::*;

    logic signed [63:0]       r_p   [N_LANES][N_TERMS];
    logic signed [32:0]       r_c   [N_LANES][N_TERMS];
    logic signed [65:0]       r_lo  [N_LANES][N_TERMS];
    logic signed [64:0]       r_hi  [N_LANES][N_TERMS];
    logic signed [W_TERM-1:0] r_t   [N_LANES][N_TERMS];
    logic signed [W_SUM-1:0]  r_s2  [N_LANES][3];
    logic signed [W_SUM-1:0]  r_sum [N_LANES];

    // Stage 1: pair product, and the third factor with the term sign folded in.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                for (int k = 0; k < N_TERMS; k++) begin
                    r_p[l][k] <= i_op[TERMS[l][k].i0] * i_op[TERMS[l][k].i1];
                    if (TERMS[l][k].neg) begin
                        r_c[l][k] <= 33'sd0 - 33'(i_op[TERMS[l][k].i2]);
                    end else begin
                        r_c[l][k] <= 33'(i_op[TERMS[l][k].i2]);
                    end
                end
            end
        end
    end

    // Stage 2: two partial products of the 64-bit pair product and the third factor.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                for (int k = 0; k < N_TERMS; k++) begin
                    r_lo[l][k] <= $signed({1'b0, r_p[l][k][31:0]}) * r_c[l][k];
                    r_hi[l][k] <= $signed(r_p[l][k][63:32]) * r_c[l][k];
                end
            end
        end
    end

    // Stage 3: recombine the partial products into the exact triple product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                for (int k = 0; k < N_TERMS; k++) begin
                    r_t[l][k] <= $signed({r_hi[l][k], 32'd0}) + W_TERM'(r_lo[l][k]);
                end
            end
        end
    end

    // Stage 4: add the terms in pairs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                for (int m = 0; m < 3; m++) begin
                    r_s2[l][m] <= W_SUM'(r_t[l][2*m]) + W_SUM'(r_t[l][2*m+1]);
                end
            end
        end
    end

    // Stage 5: final three-input sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < N_LANES; l++) begin
                r_sum[l] <= r_s2[l][0] + r_s2[l][1] + r_s2[l][2];
            end
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ===== sv/t3ls_div.sv =====
// Pipelined restoring divider: overflow check, one quotient bit per stage, saturation.
`timescale 1ns / 1ps
`default_nettype none
module t3ls_div #(
    parameter int FRAC_BITS = t3ls_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [t3ls_pkg::W_MAG-1:0]     i_d,
    input  wire logic [t3ls_pkg::W_MAG+FRAC_BITS-1:0] i_n [3],
    input  wire t3ls_pkg::t_div_ctl             i_ctl,
    output t3ls_pkg::t_res                      o_res
);
    import t3ls_pkg::*;

    localparam int NW = W_MAG + FRAC_BITS;
    localparam int CW = ((NW > W_MAG + Q_BITS) ? NW : (W_MAG + Q_BITS)) + 1;

    logic [CW-1:0]     r_rem [Q_BITS+1][3];
    logic [Q_BITS-1:0] r_q   [Q_BITS+1][3];
    logic [2:0]        r_ovf [Q_BITS+1];
    logic [W_MAG-1:0]  r_d   [Q_BITS+1];
    t_div_ctl          r_ctl [Q_BITS+1];
    t_res              r_res;

    // Stage 0: flag quotients of 2^33 or more; they saturate whatever their low bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_rem[0][j] <= {{(CW-NW){1'b0}}, i_n[j]};
                r_q[0][j]   <= '0;
                r_ovf[0][j] <= {{(CW-NW){1'b0}}, i_n[j]} >=
                               ({{(CW-W_MAG){1'b0}}, i_d} << Q_BITS);
            end
            r_d[0]   <= i_d;
            r_ctl[0] <= i_ctl;
        end
    end

    // Stages 1 to Q_BITS: one compare and subtract per quotient bit, most significant first.
    for (genvar s = 1; s <= Q_BITS; s++) begin : g_bit
        localparam int BIT = Q_BITS - s;
        logic [CW-1:0] w_dsh;
        assign w_dsh = {{(CW-W_MAG){1'b0}}, r_d[s-1]} << BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    if (r_rem[s-1][j] >= w_dsh) begin
                        r_rem[s][j] <= r_rem[s-1][j] - w_dsh;
                        r_q[s][j]   <= {r_q[s-1][j][Q_BITS-2:0], 1'b1};
                    end else begin
                        r_rem[s][j] <= r_rem[s-1][j];
                        r_q[s][j]   <= {r_q[s-1][j][Q_BITS-2:0], 1'b0};
                    end
                end
                r_ovf[s] <= r_ovf[s-1];
                r_d[s]   <= r_d[s-1];
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // Final stage: clip to range, apply sign, and force zero on a singular matrix.
    logic [W_DATA-1:0] w_sol [3];
    logic [2:0]        w_sat;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [Q_BITS-1:0] thr;
            logic [Q_BITS-1:0] q;
            logic              ng;
            q  = r_q[Q_BITS][j];
            ng = r_ctl[Q_BITS].neg[j];
            thr = ng ? {1'b0, SOL_MIN} : {1'b0, SOL_MAX};
            w_sat[j] = !r_ctl[Q_BITS].singular && (r_ovf[Q_BITS][j] || (q > thr));
            if (r_ctl[Q_BITS].singular) begin
                w_sol[j] = '0;
            end else if (w_sat[j]) begin
                w_sol[j] = ng ? SOL_MIN : SOL_MAX;
            end else if (ng) begin
                w_sol[j] = 32'd0 - q[W_DATA-1:0];
            end else begin
                w_sol[j] = q[W_DATA-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.sol_0     <= w_sol[0];
            r_res.sol_1     <= w_sol[1];
            r_res.sol_2     <= w_sol[2];
            r_res.singular  <= r_ctl[Q_BITS].singular;
            r_res.saturated <= |w_sat;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire
